// ===== rtl/mst_pkg.sv =====
// Shared types, codes and constant tables for the matrix stack engine.
// No dependencies; every rtl file imports it.
package mst_pkg;

	typedef enum logic [2:0] {
		OP_INIT, OP_PUSH, OP_POP, OP_IDENT, OP_ROTX, OP_ROTY, OP_ROTZ, OP_XFORM
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK, STAT_FULL, STAT_DEEP
	} status_t;

	localparam logic REG_NORM  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic signed [31:0] Q_ONE = 32'sd65536;

	typedef struct packed {
		logic [1:0] k;  // output component / matrix column
		logic [1:0] t;  // matrix row / vector component
	} xf_idx_t;

	// arctan(2^-i) in Q2.30 quarter turns, scaled so that 2^30 is a quarter turn
	function automatic logic signed [31:0] atan_val(input logic [4:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0: v = 32'sd536870912;
			5'd1: v = 32'sd316933406;
			5'd2: v = 32'sd167458907;
			5'd3: v = 32'sd85004756;
			5'd4: v = 32'sd42667331;
			5'd5: v = 32'sd21354465;
			5'd6: v = 32'sd10679838;
			5'd7: v = 32'sd5340245;
			5'd8: v = 32'sd2670163;
			5'd9: v = 32'sd1335087;
			5'd10: v = 32'sd667544;
			5'd11: v = 32'sd333772;
			5'd12: v = 32'sd166886;
			5'd13: v = 32'sd83443;
			5'd14: v = 32'sd41722;
			5'd15: v = 32'sd20861;
			5'd16: v = 32'sd10430;
			5'd17: v = 32'sd5215;
			5'd18: v = 32'sd2608;
			5'd19: v = 32'sd1304;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	// init matrix is diag(-1,-1,1,1), identity is diag(1,1,1,1)
	function automatic logic signed [31:0] fill_word(input logic [3:0] idx, input logic init);
		logic signed [31:0] v;
		if (idx[1:0] != idx[3:2]) begin
			v = '0;
		end else if (init && !idx[3]) begin
			v = -Q_ONE;
		end else begin
			v = Q_ONE;
		end
		return v;
	endfunction

	// read order of the 3x3 product: three rows per output component
	function automatic xf_idx_t xf_map(input logic [3:0] n);
		xf_idx_t r;
		case (n)
			4'd0: r = '{k: 2'd0, t: 2'd0};
			4'd1: r = '{k: 2'd0, t: 2'd1};
			4'd2: r = '{k: 2'd0, t: 2'd2};
			4'd3: r = '{k: 2'd1, t: 2'd0};
			4'd4: r = '{k: 2'd1, t: 2'd1};
			4'd5: r = '{k: 2'd1, t: 2'd2};
			4'd6: r = '{k: 2'd2, t: 2'd0};
			4'd7: r = '{k: 2'd2, t: 2'd1};
			4'd8: r = '{k: 2'd2, t: 2'd2};
			default: r = '{k: 2'd0, t: 2'd0};
		endcase
		return r;
	endfunction

	// Q32.32 sum back to Q16.16: round half up, saturate
	function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] a);
		logic signed [65:0] t;
		logic signed [31:0] r;
		t = (a + 66'sd32768) >>> 16;
		if (t > 66'sd2147483647) begin
			r = 32'h7FFFFFFF;
		end else if (t < -66'sd2147483648) begin
			r = 32'h80000000;
		end else begin
			r = 32'(t);
		end
		return r;
	endfunction

endpackage

// ===== rtl/matrix_stack_rotate_transform.sv =====
// Matrix stack engine top level: sequencer, matrix store, shared multiplier.
// Depends on mst_pkg, mst_cordic, mst_isqrt, mst_div.
//
// A stack of 4x4 Q16.16 matrices lives in one single-port-write, single-port-read
// memory (16 words per entry); each request runs one operation on the top entry
// and returns exactly one result. The block takes one request at a time and is
// not ready while a request is in work; a finished result waits in the output
// register, so the next request may be taken while it is still pending. Request
// time is set by the one memory read port and the one 32x32 multiplier: init and
// identity write one word per cycle, push copies 16 words, rotations run the
// CORDIC sine/cosine and then each column in turn, and a transform with
// normalization on adds the squares, the square root and then three divisions.
// After reset the block writes the initial top matrix before it takes its first
// request; configuration writes are taken at any time.
module matrix_stack_rotate_transform import mst_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// requests
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,   // angle[15:0], pop_count[20:16], vec_x[52:21],
	                                // vec_y[84:53], vec_z[116:85], zero pad
	input  logic [2:0]   s_tuser,   // mode
	// results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64],
	                                // depth[100:96], zero pad
	output logic [1:0]   m_tuser    // status
);

	localparam int EW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = EW + 4;
	localparam int MW = STACK_DEPTH * 16;

	typedef enum logic [3:0] {
		ST_FILL, ST_IDLE, ST_COPY, ST_CS, ST_ROT, ST_XF, ST_NSQ, ST_NRT, ST_NDIV, ST_DONE
	} state_t;

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic [2:0]         ph_q;
	logic [1:0]         j_q, dk_q, pr_q, qr_q;
	logic [EW-1:0]      e_q;
	logic [LW-1:0]      level_q;
	logic               fill_init_q, boot_q, norm_q;
	logic [4:0]         limit_q;
	op_t                mode_q;
	status_t            status_q;
	logic signed [31:0] vx_q, vy_q, vz_q, ox_q, oy_q, oz_q, a_q, b_q, resp_q;
	logic signed [65:0] acc_q;
	logic [31:0]        len_q;
	logic               m_tvalid_q;
	logic signed [31:0] outx_q, outy_q, outz_q;
	logic [4:0]         depth_q;
	logic [1:0]         stat_q;

	// store and multiplier datapath
	logic signed [31:0] mem [MW];
	logic signed [31:0] rdata_q;
	logic signed [63:0] prod_q;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic signed [31:0] mem_wdata, mul_x, mul_y;

	// request fields
	op_t                in_mode;
	logic [4:0]         in_pop;
	logic [15:0]        in_angle;

	logic [EW-1:0]      top_e, e_nx;
	logic               push_ok, accept;
	logic signed [31:0] kp, kq, sin_v, cos_v, comp, q_sat;
	logic [31:0]        mag;
	logic [47:0]        num, quo;
	logic [3:0]         n1, n2, n3;
	xf_idx_t            map0, map1, map2, map3;
	logic               cs_start, cs_done, rt_start, rt_done, dv_start, dv_done;
	logic [31:0]        root;

	assign in_mode  = op_t'(s_tuser);
	assign in_angle = s_tdata[15:0];
	assign in_pop   = s_tdata[20:16];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign top_e    = EW'(level_q - 1'b1);
	assign e_nx     = e_q + 1'b1;
	assign push_ok  = (8'(level_q) < 8'(limit_q)) && (8'(level_q) < 8'(STACK_DEPTH));

	// rotation coefficients: the Y rotation runs with the sine negated
	assign kp = (mode_q == OP_ROTY) ? -sin_v : sin_v;
	assign kq = -kp;

	assign n1   = 4'(cnt_q - 5'd1);
	assign n2   = 4'(cnt_q - 5'd2);
	assign n3   = 4'(cnt_q - 5'd3);
	assign map0 = xf_map(cnt_q[3:0]);
	assign map1 = xf_map(n1);
	assign map2 = xf_map(n2);
	assign map3 = xf_map(n3);

	function automatic logic signed [31:0] pick3(input logic [1:0] s,
		input logic signed [31:0] v0, input logic signed [31:0] v1,
		input logic signed [31:0] v2);
		logic signed [31:0] r;
		case (s)
			2'd0: r = v0;
			2'd1: r = v1;
			default: r = v2;
		endcase
		return r;
	endfunction

	// normalization divide: |d|*2^16 + len/2, sign restored with saturation
	assign comp  = pick3(dk_q, ox_q, oy_q, oz_q);
	assign mag   = comp[31] ? 32'(-comp) : 32'(comp);
	assign num   = {mag, 16'b0} + 48'(len_q >> 1);
	always_comb begin
		if (!comp[31]) begin
			q_sat = (quo > 48'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(quo[31:0]);
		end else begin
			q_sat = (quo > 48'h80000000) ? 32'h80000000 : -32'(quo[31:0]);
		end
	end

	assign cs_start = accept && (in_mode == OP_ROTX || in_mode == OP_ROTY ||
	                             in_mode == OP_ROTZ);
	assign rt_start = (state_q == ST_NSQ) && (cnt_q == 5'd4);
	assign dv_start = (state_q == ST_NDIV) && (ph_q == 3'd0);

	mst_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cs_start),
		.angle   (in_angle),
		.done    (cs_done),
		.sin_val (sin_v),
		.cos_val (cos_v)
	);

	mst_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_start),
		.rad    (acc_q[63:0]),
		.done   (rt_done),
		.root   (root)
	);

	mst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (num),
		.den    (len_q),
		.done   (dv_done),
		.quo    (quo)
	);

	// memory port and multiplier operand steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mul_x     = '0;
		mul_y     = '0;
		case (state_q)
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = {e_q, cnt_q[3:0]};
				mem_wdata = fill_word(cnt_q[3:0], fill_init_q);
			end
			ST_COPY: begin
				if (!cnt_q[4]) begin
					mem_re    = 1'b1;
					mem_raddr = {e_q, cnt_q[3:0]};
				end
				if (cnt_q != 5'd0) begin
					mem_we    = 1'b1;
					mem_waddr = {e_nx, n1};
					mem_wdata = rdata_q;
				end
			end
			ST_ROT: begin
				case (ph_q)
					3'd0: begin mem_re = 1'b1; mem_raddr = {e_q, pr_q, j_q}; end
					3'd1: begin mem_re = 1'b1; mem_raddr = {e_q, qr_q, j_q}; end
					3'd2: begin mul_x = a_q; mul_y = cos_v; end
					3'd3: begin mul_x = b_q; mul_y = kp; end
					3'd4: begin mul_x = b_q; mul_y = cos_v; end
					3'd5: begin mul_x = a_q; mul_y = kq; end
					3'd6: begin
						mem_we    = 1'b1;
						mem_waddr = {e_q, pr_q, j_q};
						mem_wdata = resp_q;
					end
					default: begin
						mem_we    = 1'b1;
						mem_waddr = {e_q, qr_q, j_q};
						mem_wdata = rnd_sat(acc_q);
					end
				endcase
			end
			ST_XF: begin
				if (cnt_q < 5'd9) begin
					mem_re    = 1'b1;
					mem_raddr = {e_q, map0.t, map0.k};
				end
				if (cnt_q >= 5'd1 && cnt_q <= 5'd9) begin
					mul_x = rdata_q;
					mul_y = pick3(map1.t, vx_q, vy_q, vz_q);
				end
			end
			ST_NSQ: begin
				mul_x = pick3(cnt_q[1:0], ox_q, oy_q, oz_q);
				mul_y = mul_x;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
		prod_q <= mul_x * mul_y;
	end

	// sequencer, configuration registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			ph_q        <= '0;
			j_q         <= '0;
			dk_q        <= '0;
			pr_q        <= '0;
			qr_q        <= '0;
			e_q         <= '0;
			level_q     <= LW'(1);
			fill_init_q <= 1'b1;
			boot_q      <= 1'b1;
			norm_q      <= 1'b0;
			limit_q     <= 5'd16;
			mode_q      <= OP_INIT;
			status_q    <= STAT_OK;
			vx_q        <= '0;
			vy_q        <= '0;
			vz_q        <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			resp_q      <= '0;
			acc_q       <= '0;
			len_q       <= '0;
			m_tvalid_q  <= 1'b0;
			outx_q      <= '0;
			outy_q      <= '0;
			outz_q      <= '0;
			depth_q     <= '0;
			stat_q      <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[2])
					REG_NORM:  norm_q  <= pwdata[0];
					REG_LIMIT: limit_q <= pwdata[4:0];
					default: ;
				endcase
			end
			// a result loaded in ST_DONE takes over from the drain
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_FILL: begin
					if (cnt_q == 5'd15) begin
						cnt_q   <= '0;
						boot_q  <= 1'b0;
						state_q <= boot_q ? ST_IDLE : ST_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q   <= in_mode;
						vx_q     <= s_tdata[52:21];
						vy_q     <= s_tdata[84:53];
						vz_q     <= s_tdata[116:85];
						status_q <= STAT_OK;
						cnt_q    <= '0;
						ph_q     <= '0;
						j_q      <= '0;
						e_q      <= (in_mode == OP_INIT) ? '0 : top_e;
						case (in_mode)
							OP_INIT: begin
								level_q     <= LW'(1);
								fill_init_q <= 1'b1;
								state_q     <= ST_FILL;
							end
							OP_PUSH: begin
								if (push_ok) begin
									state_q <= ST_COPY;
								end else begin
									status_q <= STAT_FULL;
									state_q  <= ST_DONE;
								end
							end
							OP_POP: begin
								if (8'(in_pop) < 8'(level_q)) begin
									level_q <= LW'(8'(level_q) - 8'(in_pop));
								end else begin
									status_q <= STAT_DEEP;
								end
								state_q <= ST_DONE;
							end
							OP_IDENT: begin
								fill_init_q <= 1'b0;
								state_q     <= ST_FILL;
							end
							OP_ROTX: begin
								pr_q <= 2'd1; qr_q <= 2'd2; state_q <= ST_CS;
							end
							OP_ROTY: begin
								pr_q <= 2'd0; qr_q <= 2'd2; state_q <= ST_CS;
							end
							OP_ROTZ: begin
								pr_q <= 2'd0; qr_q <= 2'd1; state_q <= ST_CS;
							end
							OP_XFORM: state_q <= ST_XF;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_COPY: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						level_q <= level_q + 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_CS: begin
					if (cs_done) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					// per column: read a, read b, four products, two write-backs
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: a_q <= rdata_q;
						3'd2: b_q <= rdata_q;
						3'd3: acc_q <= 66'(prod_q);
						3'd4: acc_q <= acc_q + 66'(prod_q);
						3'd5: begin
							resp_q <= rnd_sat(acc_q);
							acc_q  <= 66'(prod_q);
						end
						3'd6: acc_q <= acc_q + 66'(prod_q);
						3'd7: begin
							if (j_q == 2'd3) begin
								state_q <= ST_DONE;
							end else begin
								j_q <= j_q + 2'd1;
							end
						end
						default: ;
					endcase
				end
				ST_XF: begin
					// read, multiply, accumulate, round: four-deep stream
					if (cnt_q >= 5'd2 && cnt_q <= 5'd10) begin
						acc_q <= (map2.t == 2'd0) ? 66'(prod_q) : acc_q + 66'(prod_q);
					end
					if (cnt_q >= 5'd3 && map3.t == 2'd2) begin
						case (map3.k)
							2'd0: ox_q <= rnd_sat(acc_q);
							2'd1: oy_q <= rnd_sat(acc_q);
							default: oz_q <= rnd_sat(acc_q);
						endcase
					end
					if (cnt_q == 5'd11) begin
						cnt_q   <= '0;
						state_q <= norm_q ? ST_NSQ : ST_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_NSQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd1) begin
						acc_q <= 66'(prod_q);
					end else if (cnt_q == 5'd2 || cnt_q == 5'd3) begin
						acc_q <= acc_q + 66'(prod_q);
					end else if (cnt_q == 5'd4) begin
						state_q <= ST_NRT;
					end
				end
				ST_NRT: begin
					if (rt_done) begin
						len_q <= root;
						if (root == 32'd0) begin
							ox_q    <= '0;
							oy_q    <= '0;
							oz_q    <= '0;
							state_q <= ST_DONE;
						end else begin
							dk_q    <= '0;
							ph_q    <= '0;
							state_q <= ST_NDIV;
						end
					end
				end
				ST_NDIV: begin
					if (ph_q == 3'd0) begin
						ph_q <= 3'd1;
					end else if (dv_done) begin
						case (dk_q)
							2'd0: ox_q <= q_sat;
							2'd1: oy_q <= q_sat;
							default: oz_q <= q_sat;
						endcase
						ph_q <= '0;
						if (dk_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							dk_q <= dk_q + 2'd1;
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						outx_q     <= (mode_q == OP_XFORM) ? ox_q : 32'sd0;
						outy_q     <= (mode_q == OP_XFORM) ? oy_q : 32'sd0;
						outz_q     <= (mode_q == OP_XFORM) ? oz_q : 32'sd0;
						depth_q    <= 5'(level_q);
						stat_q     <= status_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NORM:  prdata = 32'(norm_q);
			REG_LIMIT: prdata = 32'(limit_q);
			default:   prdata = '0;
		endcase
	end

	assign pready   = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b0, depth_q, outz_q, outy_q, outx_q};
	assign m_tuser  = stat_q;

	// level stays within one and the stack depth
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q != '0 && 8'(level_q) <= 8'(STACK_DEPTH))
		else $error("stack level out of range");

	// a copy never targets an entry past the end of the store
	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> 8'(level_q) < 8'(STACK_DEPTH))
		else $error("push copy beyond store");

	// one request at a time: taking a request drops ready
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

// ===== rtl/mst_cordic.sv =====
// Iterative sine/cosine: 20 CORDIC steps on one shared add/shift datapath.
// Depends on mst_pkg (arctan table).
module mst_cordic import mst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        angle,
	output logic               done,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	logic signed [33:0] x_q, y_q, z_q;
	logic        [4:0]  i_q;
	logic               run_q, fin_q, done_q, axis_q;
	logic        [1:0]  quad_q;
	logic signed [31:0] sin_q, cos_q;

	logic signed [33:0] dx, dy, at, xr, yr;
	logic signed [31:0] cs, sn;

	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd65536) begin
			r = Q_ONE;
		end else if (v < -34'sd65536) begin
			r = -Q_ONE;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = 34'(atan_val(i_q));
	assign xr = (x_q + 34'sd8192) >>> 14;
	assign yr = (y_q + 34'sd8192) >>> 14;
	assign cs = axis_q ? Q_ONE : clamp_unit(xr);
	assign sn = axis_q ? 32'sd0 : clamp_unit(yr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			i_q    <= '0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			axis_q <= 1'b0;
			quad_q <= '0;
			sin_q  <= '0;
			cos_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= 34'sd652032874;
				y_q    <= '0;
				z_q    <= {4'b0, angle[13:0], 16'b0};
				i_q    <= '0;
				quad_q <= angle[15:14];
				axis_q <= (angle[13:0] == 14'd0);
				run_q  <= 1'b1;
			end else if (run_q) begin
				if (!z_q[33]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 5'd1;
				if (i_q == 5'd19) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				case (quad_q)
					2'd0: begin cos_q <= cs;  sin_q <= sn;  end
					2'd1: begin cos_q <= -sn; sin_q <= cs;  end
					2'd2: begin cos_q <= -cs; sin_q <= -sn; end
					default: begin cos_q <= sn; sin_q <= -cs; end
				endcase
			end
		end
	end

	assign done    = done_q;
	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

// ===== rtl/mst_isqrt.sv =====
// Floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on mst_pkg only by convention.
module mst_isqrt import mst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  i_q;
	logic        run_q, done_q;
	logic [33:0] rem2, trial;

	assign rem2  = {rem_q[31:0], rad_q[63:62]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			i_q    <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= rad;
				rem_q  <= '0;
				root_q <= '0;
				i_q    <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (rem2 >= trial) begin
					rem_q  <= rem2 - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem2;
					root_q <= {root_q[30:0], 1'b0};
				end
				i_q <= i_q + 5'd1;
				if (i_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/mst_div.sv =====
// Restoring divider, 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on mst_pkg only by convention.
module mst_div import mst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quo
);

	logic [47:0] q_q;
	logic [31:0] rem_q, den_q;
	logic [5:0]  i_q;
	logic        run_q, done_q;
	logic [32:0] r2;

	assign r2 = {rem_q, q_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q    <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			i_q    <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q   <= num;
				den_q <= den;
				rem_q <= '0;
				i_q   <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (r2 >= {1'b0, den_q}) begin
					rem_q <= 32'(r2 - {1'b0, den_q});
					q_q   <= {q_q[46:0], 1'b1};
				end else begin
					rem_q <= r2[31:0];
					q_q   <= {q_q[46:0], 1'b0};
				end
				i_q <= i_q + 6'd1;
				if (i_q == 6'd47) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ===== verif/tb_matrix_stack_rotate_transform.sv =====
// Testbench for matrix_stack_rotate_transform: drives requests and register writes,
// predicts every result with its own matrix-stack model and checks it field by field.
// Depends on mst_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_matrix_stack_rotate_transform;
	import mst_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int SETTLE = 40;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic [4:0] depth;
		status_t st;
	} stack_result_t;

	// Own model of the stack engine; keeps matrices, level and registers.
	class stack_scoreboard;
		int mat[256];
		int unsigned level;
		int unsigned limit_reg;
		bit norm_on;
		stack_result_t pending[$];
		longint atan_q30[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304};

		function new();
			foreach (mat[i]) mat[i] = 0;
			load_start_top();
			level = 1;
			limit_reg = 16;
			norm_on = 0;
		endfunction

		function void load_start_top();
			for (int i = 0; i < 16; i++) mat[i] = 0;
			mat[0] = -65536; mat[5] = -65536; mat[10] = 65536; mat[15] = 65536;
		endfunction

		function longint clamp_unit(longint v);
			if (v > 65536) return 65536;
			if (v < -65536) return -65536;
			return v;
		endfunction

		function int sat32(logic signed [65:0] v);
			if (v > 66'sd2147483647) return 32'h7FFFFFFF;
			if (v < -66'sd2147483648) return 32'h80000000;
			return int'(v[31:0]);
		endfunction

		// quadrant folding around a CORDIC over the remainder angle
		function void sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
			longint x, y, z, dx, dy, c0, s0;
			x = 652032874; y = 0; z = longint'(ang[13:0]) << 16;
			if (ang[13:0] == 0) begin
				c0 = 65536; s0 = 0;
			end else begin
				for (int i = 0; i < 20; i++) begin
					dx = y >>> i; dy = x >>> i;
					if (z >= 0) begin
						x -= dx; y += dy; z -= atan_q30[i];
					end else begin
						x += dx; y -= dy; z += atan_q30[i];
					end
				end
				c0 = clamp_unit((x + 8192) >>> 14);
				s0 = clamp_unit((y + 8192) >>> 14);
			end
			case (ang[15:14])
				2'd0: begin cs = c0; sn = s0; end
				2'd1: begin cs = -s0; sn = c0; end
				2'd2: begin cs = -c0; sn = -s0; end
				default: begin cs = s0; sn = -c0; end
			endcase
		endfunction

		function int rot_mac(int a, longint ka, int b, longint kb);
			logic signed [65:0] acc;
			acc = 66'(longint'(a) * ka) + 66'(longint'(b) * kb) + 66'sd32768;
			return sat32(acc >>> 16);
		endfunction

		function int dot3(int a0, int b0, int a1, int b1, int a2, int b2);
			logic signed [65:0] acc;
			acc = 66'(longint'(a0) * b0) + 66'(longint'(a1) * b1)
				+ 66'(longint'(a2) * b2) + 66'sd32768;
			return sat32(acc >>> 16);
		endfunction

		function logic [63:0] isqrt(logic [63:0] v);
			logic [63:0] res, bitv;
			res = 0; bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv; res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function int to_unit(int d, logic [63:0] len);
			logic [63:0] mag, q;
			mag = d < 0 ? 64'(-longint'(d)) : 64'(longint'(d));
			q = ((mag << 16) + (len >> 1)) / len;
			return d < 0 ? sat32(-$signed({2'b0, q})) : sat32($signed({2'b0, q}));
		endfunction

		// accepted request: advance the model and queue the result it causes
		function void note_request(op_t op, logic [15:0] ang, logic [4:0] npop,
				int vx, int vy, int vz);
			stack_result_t r;
			int unsigned lim, b;
			longint sn, cs;
			int a, bb, ox, oy, oz;
			logic [63:0] mag, len;
			lim = limit_reg < 16 ? limit_reg : 16;
			b = (level - 1) * 16;
			ox = 0; oy = 0; oz = 0;
			r.st = STAT_OK;
			case (op)
				OP_INIT: begin level = 1; load_start_top(); end
				OP_PUSH: begin
					if (level < lim) begin
						for (int i = 0; i < 16; i++) mat[b + 16 + i] = mat[b + i];
						level++;
					end else begin
						r.st = STAT_FULL;
					end
				end
				OP_POP: begin
					if (npop < level) level -= npop;
					else r.st = STAT_DEEP;
				end
				OP_IDENT: begin
					for (int i = 0; i < 16; i++) mat[b + i] = (i % 5 == 0) ? 65536 : 0;
				end
				OP_ROTX: begin
					sin_cos(ang, sn, cs);
					for (int j = 0; j < 4; j++) begin
						a = mat[b + 4 + j]; bb = mat[b + 8 + j];
						mat[b + 4 + j] = rot_mac(bb, sn, a, cs);
						mat[b + 8 + j] = rot_mac(bb, cs, a, -sn);
					end
				end
				OP_ROTY: begin
					sin_cos(ang, sn, cs);
					for (int j = 0; j < 4; j++) begin
						a = mat[b + j]; bb = mat[b + 8 + j];
						mat[b + j] = rot_mac(a, cs, bb, -sn);
						mat[b + 8 + j] = rot_mac(bb, cs, a, sn);
					end
				end
				OP_ROTZ: begin
					sin_cos(ang, sn, cs);
					for (int j = 0; j < 4; j++) begin
						a = mat[b + j]; bb = mat[b + 4 + j];
						mat[b + j] = rot_mac(a, cs, bb, sn);
						mat[b + 4 + j] = rot_mac(bb, cs, a, -sn);
					end
				end
				default: begin
					ox = dot3(vz, mat[b + 8], vy, mat[b + 4], vx, mat[b + 0]);
					oy = dot3(vz, mat[b + 9], vy, mat[b + 5], vx, mat[b + 1]);
					oz = dot3(vz, mat[b + 10], vy, mat[b + 6], vx, mat[b + 2]);
					if (norm_on) begin
						mag = 64'(longint'(ox) * ox) + 64'(longint'(oy) * oy)
							+ 64'(longint'(oz) * oz);
						len = isqrt(mag);
						if (len == 0) begin
							ox = 0; oy = 0; oz = 0;
						end else begin
							ox = to_unit(ox, len); oy = to_unit(oy, len); oz = to_unit(oz, len);
						end
					end
				end
			endcase
			r.x = ox; r.y = oy; r.z = oz;
			r.depth = level[4:0];
			pending.push_back(r);
		endfunction

		// returns an empty string when the result matches the oldest expectation
		function string check_result(logic [103:0] d, logic [1:0] u);
			stack_result_t e;
			if (pending.size() == 0) return "result with nothing expected";
			e = pending.pop_front();
			if (d[31:0] !== e.x) return $sformatf("out_x %0d, want %0d", $signed(d[31:0]), e.x);
			if (d[63:32] !== e.y) return $sformatf("out_y %0d, want %0d", $signed(d[63:32]), e.y);
			if (d[95:64] !== e.z) return $sformatf("out_z %0d, want %0d", $signed(d[95:64]), e.z);
			if (d[100:96] !== e.depth) return $sformatf("depth %0d, want %0d", d[100:96], e.depth);
			if (u !== e.st) return $sformatf("status %0d, want %0d", u, e.st);
			return "";
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 0;
	logic s_tready;
	logic [119:0] s_tdata = '0;   // angle, pop_count, vec_x, vec_y, vec_z, pad
	logic [2:0] s_tuser = '0;     // mode
	logic m_tvalid;
	logic m_tready = 0;
	logic [103:0] m_tdata;        // out_x, out_y, out_z, depth, pad
	logic [1:0] m_tuser;          // status

	stack_scoreboard sb = new();
	int errors = 0;
	int cycles = 0;
	bit calm = 0;       // no idling on either side while set
	int sink_stall = 0;

	matrix_stack_rotate_transform uut (.*);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_matrix_stack_rotate_transform: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if (calm) return 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7: return $urandom_range(1, 3);
			8: return $urandom_range(4, 12);
			default: return $urandom_range(20, 80);
		endcase
	endfunction

	// result side: random stalls, check on every accepted result
	initial begin
		string msg;
		forever begin
			@(negedge clk);
			if (sink_stall > 0) begin
				sink_stall--;
				m_tready <= 0;
			end else begin
				sink_stall = pick_gap();
				m_tready <= (sink_stall == 0);
			end
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				msg = sb.check_result(m_tdata, m_tuser);
				if (msg != "") report_mismatch(msg);
			end
		end
	end

	// called at a falling edge; returns at a falling edge after the request is taken
	task automatic send_request(op_t op, logic [15:0] ang, logic [4:0] npop,
			int vx, int vy, int vz);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {3'b0, vz, vy, vx, npop, ang};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, ang, npop, vx, vy, vz);
		@(negedge clk);
	endtask

	// APB write: setup then access, only while the block is idle
	task automatic write_reg(logic idx, logic [31:0] val);
		s_tvalid <= 0;
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_NORM) sb.norm_on = val[0];
		else sb.limit_reg = val[4:0];
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		s_tvalid <= 0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic int pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			2: return $urandom_range(0, 32'h3FFFFFF) - 32'h2000000;
			default: return $urandom_range(0, 32'h7FFF) - 32'h4000;
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		if ($urandom_range(0, 5) == 0) return 16'($urandom_range(0, 3) << 14);
		return 16'($urandom());
	endfunction

	task automatic random_request();
		op_t op;
		logic [4:0] npop;
		int w;
		w = $urandom_range(0, 99);
		if (w < 3) op = OP_INIT;
		else if (w < 20) op = OP_PUSH;
		else if (w < 33) op = OP_POP;
		else if (w < 40) op = OP_IDENT;
		else if (w < 50) op = OP_ROTX;
		else if (w < 60) op = OP_ROTY;
		else if (w < 70) op = OP_ROTZ;
		else op = OP_XFORM;
		npop = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 16))
			: 5'($urandom_range(0, 3));
		send_request(op, pick_angle(), npop, pick_coord(), pick_coord(), pick_coord());
	endtask

	initial begin
		int phase_norm[6] = '{0, 1, 0, 1, 0, 1};
		int phase_limit[6] = '{16, 1, 5, 16, 1, 9};
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: stack edges, axis angles, extreme vectors
		calm = 1;
		for (int i = 0; i < 16; i++) send_request(OP_PUSH, 0, 0, 0, 0, 0);
		send_request(OP_POP, 0, 0, 0, 0, 0);
		send_request(OP_POP, 0, 16, 0, 0, 0);
		send_request(OP_POP, 0, 15, 0, 0, 0);
		send_request(OP_XFORM, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_request(OP_ROTX, 16'h4000, 0, 0, 0, 0);
		send_request(OP_ROTY, 16'h8000, 0, 0, 0, 0);
		send_request(OP_ROTZ, 16'hFFFF, 0, 0, 0, 0);
		send_request(OP_ROTX, 16'h0001, 0, 0, 0, 0);
		send_request(OP_ROTZ, 16'hC000, 0, 0, 0, 0);
		send_request(OP_XFORM, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(OP_IDENT, 0, 0, 0, 0, 0);
		send_request(OP_INIT, 0, 31, 0, 0, 0);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_NORM, phase_norm[p]);
			write_reg(REG_LIMIT, phase_limit[p]);
			calm = (p == 2);
			if (phase_norm[p] == 1 && p == 1) begin
				// zero vector and a full-scale one under normalization
				send_request(OP_XFORM, 0, 0, 0, 0, 0);
				send_request(OP_XFORM, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
				send_request(OP_PUSH, 0, 0, 0, 0, 0);
			end
			repeat (130) random_request();
			drain();
		end

		if (errors == 0)
			$display("tb_matrix_stack_rotate_transform: done, clean");
		else
			$display("tb_matrix_stack_rotate_transform: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mst_pkg.sv
rtl/mst_cordic.sv
rtl/mst_isqrt.sv
rtl/mst_div.sv
rtl/matrix_stack_rotate_transform.sv
verif/tb_matrix_stack_rotate_transform.sv
